>>> rtl/dsqt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsqt_pkg
// Sizes and codes shared by the delta sleep queue timer.
// ----------------------------------------------------------------------------
package dsqt_pkg;

  localparam int MAX_SLEEPERS = 16;
  localparam int ID_BITS      = 8;
  localparam int TIME_BITS    = 16;

  // list index and fill count widths
  localparam int IDX_W = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
  localparam int CNT_W = $clog2(MAX_SLEEPERS + 1);

  // request opcodes
  localparam logic [1:0] OP_SLEEP = 2'd0;
  localparam logic [1:0] OP_SLICE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_WOKEN  = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_FULL   = 2'd3;

endpackage

>>> rtl/delta_sleep_queue_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_sleep_queue_timer
// Delta-ordered sleep list with a time-slice counter, one request at a time.
// ----------------------------------------------------------------------------
// One request is taken at a time; in_stall stays high from acceptance until
// its final result has been loaded into the output register. A start_slice
// request, a zero-length sleep or a rejected sleep goes straight to its
// final result. An accepted sleep walks past up to MAX_SLEEPERS - 1 list
// entries before it is inserted, because one shared subtractor compares and
// subtracts one list delta per cycle and then fixes up the follower's delta.
// A tick and a flush give one result per cycle for each thread woken while
// out_stall is low, the shared subtractor also doing the head and slice
// decrements for a tick. Every result waits while out_stall is high.
// ----------------------------------------------------------------------------
module delta_sleep_queue_timer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_opcode,
  input  logic [dsqt_pkg::ID_BITS-1:0]   in_thread_id,
  input  logic [dsqt_pkg::TIME_BITS-1:0] in_duration,
  input  logic                           in_running_is_idle,
  input  logic                           in_running_has_slice,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_kind,
  output logic [dsqt_pkg::ID_BITS-1:0]   out_woken_id,
  output logic                           out_preempt,
  output logic                           out_last
);

  localparam int MAX = dsqt_pkg::MAX_SLEEPERS;
  localparam int IW  = dsqt_pkg::IDX_W;
  localparam int CW  = dsqt_pkg::CNT_W;
  localparam int TW  = dsqt_pkg::TIME_BITS;
  localparam int DW  = dsqt_pkg::ID_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_INSERT, S_TDEC, S_WAKE, S_SLICE, S_FINAL
  } state_t;

  state_t        state_r, state_nxt;
  logic [DW-1:0] ids_r    [MAX];
  logic [DW-1:0] ids_nxt  [MAX];
  logic [TW-1:0] deltas_r [MAX];
  logic [TW-1:0] deltas_nxt [MAX];
  logic [CW-1:0] count_r, count_nxt;
  logic [TW-1:0] slice_r, slice_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic [TW-1:0] rem_r, rem_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [DW-1:0] id_r, id_nxt;
  logic          idle_r, idle_nxt;
  logic          has_slice_r, has_slice_nxt;
  logic [1:0]    fin_kind_r, fin_kind_nxt;
  logic          fin_pre_r, fin_pre_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_kind_r, out_kind_nxt;
  logic [DW-1:0] out_id_r, out_id_nxt;
  logic          out_pre_r, out_pre_nxt;
  logic          out_last_r, out_last_nxt;

  // shared subtractor; top bit is the borrow
  logic [TW-1:0] sub_a, sub_b;
  logic [TW:0]   sub_d;
  logic [TW-1:0] delta_at_pos;
  logic          slot_free;
  logic          accept;

  assign delta_at_pos = deltas_r[pos_r];
  assign sub_d        = {1'b0, sub_a} - {1'b0, sub_b};
  assign slot_free    = !out_valid_r || !out_stall;
  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && !in_stall;

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_woken_id = out_id_r;
  assign out_preempt  = out_pre_r;
  assign out_last     = out_last_r;

  always_comb begin
    unique case (state_r)
      S_INSERT: begin
        sub_a = delta_at_pos;
        sub_b = rem_r;
      end
      S_TDEC: begin
        sub_a = deltas_r[0];
        sub_b = TW'(1);
      end
      S_SLICE: begin
        sub_a = slice_r;
        sub_b = TW'(1);
      end
      default: begin
        sub_a = rem_r;
        sub_b = delta_at_pos;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ids_nxt       = ids_r;
    deltas_nxt    = deltas_r;
    count_nxt     = count_r;
    slice_nxt     = slice_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    idle_nxt      = idle_r;
    has_slice_nxt = has_slice_r;
    fin_kind_nxt  = fin_kind_r;
    fin_pre_nxt   = fin_pre_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_pre_nxt   = out_pre_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt        = in_opcode;
          id_nxt        = in_thread_id;
          rem_nxt       = in_duration;
          idle_nxt      = in_running_is_idle;
          has_slice_nxt = in_running_has_slice;
          pos_nxt       = '0;
          fin_pre_nxt   = 1'b0;
          unique case (in_opcode)
            dsqt_pkg::OP_SLEEP: begin
              if (in_duration == '0) begin
                fin_kind_nxt = dsqt_pkg::KIND_WOKEN;
                state_nxt    = S_FINAL;
              end else if (count_r >= CW'(MAX)) begin
                fin_kind_nxt = dsqt_pkg::KIND_FULL;
                state_nxt    = S_FINAL;
              end else begin
                state_nxt = S_WALK;
              end
            end
            dsqt_pkg::OP_SLICE: begin
              slice_nxt    = in_duration;
              fin_kind_nxt = dsqt_pkg::KIND_DONE;
              state_nxt    = S_FINAL;
            end
            dsqt_pkg::OP_TICK: state_nxt = S_TDEC;
            default:           state_nxt = S_WAKE;
          endcase
        end
      end
      S_WALK: begin
        // step past entries that wake no later than the new sleeper
        if (CW'(pos_r) == count_r || sub_d[TW]) begin
          state_nxt = S_INSERT;
        end else begin
          rem_nxt = sub_d[TW-1:0];
          pos_nxt = pos_r + IW'(1);
        end
      end
      S_INSERT: begin
        for (int i = 1; i < MAX; i++) begin
          if (IW'(i) > pos_r) begin
            ids_nxt[i]    = ids_r[i-1];
            deltas_nxt[i] = (IW'(i) == pos_r + IW'(1)) ? sub_d[TW-1:0] : deltas_r[i-1];
          end
        end
        ids_nxt[pos_r]    = id_r;
        deltas_nxt[pos_r] = rem_r;
        count_nxt         = count_r + CW'(1);
        fin_kind_nxt      = dsqt_pkg::KIND_ACCEPT;
        state_nxt         = S_FINAL;
      end
      S_TDEC: begin
        if (count_r != '0 && deltas_r[0] != '0) begin
          deltas_nxt[0] = sub_d[TW-1:0];
        end
        state_nxt = S_WAKE;
      end
      S_WAKE: begin
        if (count_r != '0 && (op_r == dsqt_pkg::OP_FLUSH || deltas_r[0] == '0)) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = dsqt_pkg::KIND_WOKEN;
            out_id_nxt    = ids_r[0];
            out_pre_nxt   = 1'b0;
            out_last_nxt  = 1'b0;
            for (int i = 0; i < MAX - 1; i++) begin
              ids_nxt[i]    = ids_r[i+1];
              deltas_nxt[i] = deltas_r[i+1];
            end
            count_nxt = count_r - CW'(1);
          end
        end else begin
          fin_kind_nxt = dsqt_pkg::KIND_DONE;
          state_nxt    = (op_r == dsqt_pkg::OP_TICK) ? S_SLICE : S_FINAL;
        end
      end
      S_SLICE: begin
        if (idle_r) begin
          fin_pre_nxt = 1'b1;
        end else if (has_slice_r) begin
          if (slice_r != '0) begin
            slice_nxt   = sub_d[TW-1:0];
            fin_pre_nxt = (sub_d[TW-1:0] == '0);
          end else begin
            fin_pre_nxt = 1'b1;
          end
        end
        state_nxt = S_FINAL;
      end
      S_FINAL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = fin_kind_r;
          out_id_nxt    = (fin_kind_r == dsqt_pkg::KIND_WOKEN) ? id_r : '0;
          out_pre_nxt   = fin_pre_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      slice_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      slice_r     <= slice_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ids_r       <= ids_nxt;
    deltas_r    <= deltas_nxt;
    pos_r       <= pos_nxt;
    rem_r       <= rem_nxt;
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    idle_r      <= idle_nxt;
    has_slice_r <= has_slice_nxt;
    fin_kind_r  <= fin_kind_nxt;
    fin_pre_r   <= fin_pre_nxt;
    out_kind_r  <= out_kind_nxt;
    out_id_r    <= out_id_nxt;
    out_pre_r   <= out_pre_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX))
    else $error("sleep list count beyond capacity");

  a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (CW'(pos_r) <= count_r))
    else $error("walk pointer past end of list");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (count_r == $past(count_r) || count_r == $past(count_r) + CW'(1)
                      || count_r == $past(count_r) - CW'(1)))
    else $error("list count moved by more than one");

  a_preempt_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pre_r) |-> (out_last_r && out_kind_r == dsqt_pkg::KIND_DONE))
    else $error("preempt on a non-final result");

  a_zero_sleep: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == dsqt_pkg::OP_SLEEP && in_duration == '0) |=> (state_r == S_FINAL))
    else $error("zero-length sleep did not go straight to its result");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives sleep, start_slice, tick and flush requests into the delta sleep queue
// timer and checks every result against the script or a local copy of the sleep
// list and slice counter. A short scripted sequence fills and drains the list,
// then random requests follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [1:0]                   kind;
    logic [dsqt_pkg::ID_BITS-1:0] id;
    logic                         preempt;
    logic                         last;
  } result_t;

  typedef struct packed {
    logic [1:0]                     op;
    logic [dsqt_pkg::ID_BITS-1:0]   id;
    logic [dsqt_pkg::TIME_BITS-1:0] dur;
    logic                           idle;
    logic                           has_slice;
    logic                           typed;     // expected result given in the script
    result_t                        exp;
  } request_t;

  localparam result_t NO_RES = '0;
  localparam int N_SCRIPT = 25;
  localparam int N_RANDOM = 345;
  localparam int DRAIN_CYCLES = 40;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [1:0]                   out_kind;
  logic [dsqt_pkg::ID_BITS-1:0] out_woken_id;
  logic                         out_preempt;
  logic                         out_last;
  request_t                     cur_req = '0;

  bit send_idle = 1'b0;
  bit recv_idle = 1'b0;
  int stall_left = 0;
  int errors = 0;

  // local copy of the sleep list and slice counter
  logic [dsqt_pkg::ID_BITS-1:0]   list_id [dsqt_pkg::MAX_SLEEPERS];
  logic [dsqt_pkg::TIME_BITS-1:0] list_delta [dsqt_pkg::MAX_SLEEPERS];
  int                             list_count = 0;
  logic [dsqt_pkg::TIME_BITS-1:0] slice_count = '0;

  result_t step_results [$];
  result_t due_results [$];

  // empty-list cases, fill to capacity, reject, then wake the head ties and flush
  request_t script [N_SCRIPT] = '{
    '{dsqt_pkg::OP_TICK,  8'h00, 16'h0000, 1'b0, 1'b1, 1'b1,
      '{dsqt_pkg::KIND_DONE,   8'h00, 1'b1, 1'b1}},
    '{dsqt_pkg::OP_FLUSH, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_DONE,   8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'hff, 16'h0000, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_WOKEN,  8'hff, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLICE, 8'h00, 16'hffff, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_DONE,   8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_TICK,  8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, NO_RES},
    '{dsqt_pkg::OP_TICK,  8'h00, 16'h0000, 1'b1, 1'b1, 1'b0, NO_RES},
    '{dsqt_pkg::OP_SLEEP, 8'h00, 16'hffff, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h01, 16'h0001, 1'b1, 1'b1, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h02, 16'h0001, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h10, 16'h0002, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h11, 16'hffff, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h12, 16'h0001, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h13, 16'h0003, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h14, 16'h8000, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h15, 16'h0002, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h16, 16'h0005, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h17, 16'h7fff, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h18, 16'h0001, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h19, 16'h0004, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h1a, 16'haaaa, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h1b, 16'h5555, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h1c, 16'h0006, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_ACCEPT, 8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_SLEEP, 8'h5a, 16'h0003, 1'b0, 1'b0, 1'b1,
      '{dsqt_pkg::KIND_FULL,   8'h00, 1'b0, 1'b1}},
    '{dsqt_pkg::OP_TICK,  8'h00, 16'h0000, 1'b0, 1'b1, 1'b0, NO_RES},
    '{dsqt_pkg::OP_FLUSH, 8'h00, 16'h0000, 1'b0, 1'b0, 1'b0, NO_RES}
  };

  delta_sleep_queue_timer u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_opcode            (cur_req.op),
    .in_thread_id         (cur_req.id),
    .in_duration          (cur_req.dur),
    .in_running_is_idle   (cur_req.idle),
    .in_running_has_slice (cur_req.has_slice),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kind             (out_kind),
    .out_woken_id         (out_woken_id),
    .out_preempt          (out_preempt),
    .out_last             (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t mk_result(logic [1:0] kind,
                                        logic [dsqt_pkg::ID_BITS-1:0] id,
                                        logic preempt, logic last);
    result_t r;
    r.kind = kind;
    r.id = id;
    r.preempt = preempt;
    r.last = last;
    return r;
  endfunction

  function automatic logic [dsqt_pkg::ID_BITS-1:0] pop_sleeper();
    logic [dsqt_pkg::ID_BITS-1:0] id;
    id = list_id[0];
    for (int i = 1; i < list_count; i++) begin
      list_id[i-1] = list_id[i];
      list_delta[i-1] = list_delta[i];
    end
    list_count--;
    return id;
  endfunction

  // works out the results of one request and updates the local list
  task automatic sleep_list_step(input request_t r);
    int                             pos;
    logic [dsqt_pkg::TIME_BITS-1:0] rem;
    logic                           preempt;
    step_results.delete();
    case (r.op)
      dsqt_pkg::OP_SLEEP: begin
        if (r.dur == '0) begin
          step_results.push_back(mk_result(dsqt_pkg::KIND_WOKEN, r.id, 1'b0, 1'b1));
        end else if (list_count >= dsqt_pkg::MAX_SLEEPERS) begin
          step_results.push_back(mk_result(dsqt_pkg::KIND_FULL, '0, 1'b0, 1'b1));
        end else begin
          pos = 0;
          rem = r.dur;
          // ties go behind every sleeper waking on the same tick
          while (pos < list_count && list_delta[pos] <= rem) begin
            rem -= list_delta[pos];
            pos++;
          end
          for (int i = list_count; i > pos; i--) begin
            list_id[i] = list_id[i-1];
            list_delta[i] = list_delta[i-1];
          end
          list_id[pos] = r.id;
          list_delta[pos] = rem;
          list_count++;
          if (pos + 1 < list_count) list_delta[pos+1] -= rem;
          step_results.push_back(mk_result(dsqt_pkg::KIND_ACCEPT, '0, 1'b0, 1'b1));
        end
      end
      dsqt_pkg::OP_SLICE: begin
        slice_count = r.dur;
        step_results.push_back(mk_result(dsqt_pkg::KIND_DONE, '0, 1'b0, 1'b1));
      end
      dsqt_pkg::OP_TICK: begin
        if (list_count > 0 && list_delta[0] != '0) list_delta[0]--;
        while (list_count > 0 && list_delta[0] == '0)
          step_results.push_back(mk_result(dsqt_pkg::KIND_WOKEN, pop_sleeper(), 1'b0, 1'b0));
        preempt = 1'b0;
        if (r.idle) begin
          preempt = 1'b1;
        end else if (r.has_slice) begin
          if (slice_count != '0) slice_count--;
          preempt = (slice_count == '0);
        end
        step_results.push_back(mk_result(dsqt_pkg::KIND_DONE, '0, preempt, 1'b1));
      end
      default: begin
        while (list_count > 0)
          step_results.push_back(mk_result(dsqt_pkg::KIND_WOKEN, pop_sleeper(), 1'b0, 1'b0));
        step_results.push_back(mk_result(dsqt_pkg::KIND_DONE, '0, 1'b0, 1'b1));
      end
    endcase
  endtask

  // request acceptance and result checking, both on the rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst_n && in_valid && !in_stall) begin
      sleep_list_step(cur_req);
      if (cur_req.typed) due_results.push_back(cur_req.exp);
      else foreach (step_results[i]) due_results.push_back(step_results[i]);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result with nothing due: kind %0d woken_id %0d", out_kind, out_woken_id);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_kind);
          errors++;
        end
        if (out_woken_id !== want.id) begin
          $error("woken_id: expected %0d, actual %0d", want.id, out_woken_id);
          errors++;
        end
        if (out_preempt !== want.preempt) begin
          $error("preempt: expected %0d, actual %0d", want.preempt, out_preempt);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (recv_idle && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 18);
    end else begin
      out_stall = 1'b0;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(input request_t r);
    if (send_idle && $urandom_range(0, 2) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    cur_req = r;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic request_t random_request();
    request_t r;
    int       pick;
    r = '0;
    pick = $urandom_range(0, 99);
    r.id = dsqt_pkg::ID_BITS'($urandom_range(0, 255));
    r.idle = ($urandom_range(0, 3) == 0);
    r.has_slice = 1'($urandom_range(0, 1));
    if (pick < 55) begin
      r.op = dsqt_pkg::OP_SLEEP;
      case ($urandom_range(0, 15))
        0:       r.dur = '0;
        1:       r.dur = '1;
        2, 3:    r.dur = dsqt_pkg::TIME_BITS'($urandom_range(0, 65535));
        default: r.dur = dsqt_pkg::TIME_BITS'($urandom_range(1, 12));
      endcase
    end else if (pick < 63) begin
      r.op = dsqt_pkg::OP_SLICE;
      r.dur = dsqt_pkg::TIME_BITS'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 10));
    end else if (pick < 93) begin
      r.op = dsqt_pkg::OP_TICK;
      r.dur = dsqt_pkg::TIME_BITS'($urandom_range(0, 65535));
    end else begin
      r.op = dsqt_pkg::OP_FLUSH;
      r.dur = dsqt_pkg::TIME_BITS'($urandom_range(0, 65535));
    end
    return r;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    foreach (script[i]) send_request(script[i]);
    for (int k = 0; k < N_RANDOM; k++) begin
      // idling switched per stretch, and off for the tail of the run
      if (k % 40 == 0) begin
        send_idle = (k < N_RANDOM - 60) && ($urandom_range(0, 3) != 0);
        recv_idle = (k < N_RANDOM - 60) && ($urandom_range(0, 3) != 0);
      end
      send_request(random_request());
    end
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule
